### rtl/wipe_alpha_premultiply_defines.svh
// Assertion macros for the wipe alpha premultiply block.
`ifndef WIPE_ALPHA_PREMULTIPLY_DEFINES_SVH
`define WIPE_ALPHA_PREMULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define WAP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define WAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wap_pkg.sv
// Types, register indexes and constants of the wipe alpha premultiply block.
package wap_pkg;

   // Largest extent along the wipe axis; larger register values are clamped.
   localparam int unsigned MAX_DIM = 4096;
   localparam logic [12:0] DIM_CAP = 13'((MAX_DIM < 8191) ? MAX_DIM : 8191);
   localparam logic [12:0] DIM_MIN = 13'd2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_WIPE_DIRECTION = 2'd2;
   localparam logic [1:0] CSR_WIPE_STAGE     = 2'd3;

   localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

   // How the wipe alpha follows from the divider quotient q
   localparam logic [1:0] KIND_ZERO = 2'd0;   // t = 0
   localparam logic [1:0] KIND_FULL = 2'd1;   // t = 255
   localparam logic [1:0] KIND_UP   = 2'd2;   // t = q
   localparam logic [1:0] KIND_DOWN = 2'd3;   // t = 255 - q

   localparam logic [7:0] ALPHA_FULL = 8'hFF;

   typedef struct packed {
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic [7:0]  blue_in;
      logic [7:0]  green_in;
      logic [7:0]  red_in;
      logic [7:0]  alpha_in;
   } wap_req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic [7:0] alpha_out;
   } wap_rsp_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } wap_pix_type;

   // Selected extent, coordinate and stage
   typedef struct packed {
      logic [12:0] dim;
      logic [11:0] pos;
      logic [5:0]  stg;
      wap_pix_type pix;
   } wap_s1_type;

   // Ramp start a, half extent b and frame check
   typedef struct packed {
      logic [11:0] ofs;
      logic [11:0] half;
      logic [11:0] pos;
      logic [1:0]  regime;
      logic        beyond;
      wap_pix_type pix;
   } wap_s2_type;

   // Region decided, distance into the ramp
   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] delta;
      logic [11:0] half;
      wap_pix_type pix;
   } wap_s3_type;

   // Restoring divider of 255*delta by half
   typedef struct packed {
      logic [19:0] rem;
      logic [11:0] half;
      logic [7:0]  quo;
      logic [1:0]  kind;
      wap_pix_type pix;
   } wap_dv_type;

   typedef struct packed {
      logic [15:0] prod_b;
      logic [15:0] prod_g;
      logic [15:0] prod_r;
      logic [7:0]  alpha;
   } wap_mp_type;

endpackage

### rtl/wipe_alpha_premultiply.sv
// Linear wipe transition with premultiplied alpha: top level and pipeline.
// One pixel per clock while responses are taken, through ten register stages.
// The extent along the wipe axis is clamped, the ramp start and half extent are
// formed, the region is decided, then 255*distance is divided by the half extent
// in a restoring divider that resolves two quotient bits in each of four stages.
// The wipe alpha is ORed into the pixel alpha, the colours are multiplied by it and
// divided by 255 with a reciprocal add. Every stage has its own valid bit and can
// fill while later stages wait, so a stalled response holds only the stages behind
// it. Writes to the configuration registers take effect for requests accepted after
// the write.
`include "wipe_alpha_premultiply_defines.svh"

module wipe_alpha_premultiply
   import wap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  wap_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output wap_rsp_type rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int unsigned NStg   = 10;
   localparam int unsigned StDv0  = 3;
   localparam int unsigned StMp   = 8;
   localparam int unsigned StOut  = 9;
   localparam int unsigned DvStgs = 4;

   function automatic wap_dv_type div_step(wap_dv_type cur, logic [2:0] sh);
      logic [19:0] dvs;
      wap_dv_type  nxt;
      nxt = cur;
      dvs = 20'(cur.half) << sh;
      if (cur.rem >= dvs) begin
         nxt.rem     = cur.rem - dvs;
         nxt.quo[sh] = 1'b1;
      end
      return nxt;
   endfunction

   // Exact floor(x/255) for x below 65280
   function automatic logic [7:0] div255(logic [15:0] x);
      logic [16:0] acc;
      acc = 17'(x) + 17'(x[15:8]) + 17'd1;
      return acc[15:8];
   endfunction

   logic [12:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic        wipe_direction_ff;
   logic [5:0]  wipe_stage_ff;

   logic [NStg-1:0] vld_ff;
   logic [NStg-1:0] en;

   wap_s1_type  s1_ff, s1_in;
   wap_s2_type  s2_ff, s2_in;
   wap_s3_type  s3_ff, s3_in;
   wap_dv_type  dv_ff [0:DvStgs];
   wap_dv_type  dv_in;
   wap_mp_type  mp_ff, mp_in;
   wap_rsp_type out_ff, out_in;

   logic div_rem_ok;
   logic colour_ok;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         wipe_direction_ff <= 1'b0;
         wipe_stage_ff     <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            CSR_WIPE_DIRECTION: wipe_direction_ff <= csr_wdata[0];
            CSR_WIPE_STAGE:     wipe_stage_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Stage loads when it is empty or its contents move on
   always_comb begin
      en[NStg-1] = !vld_ff[NStg-1] || rsp_ready;
      for (int k = NStg - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NStg; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Select axis and clamp the extent
   always_comb begin
      logic [12:0] raw;
      raw = wipe_direction_ff ? frame_height_ff : frame_width_ff;
      s1_in.dim = (raw < DIM_MIN) ? DIM_MIN : ((raw > DIM_CAP) ? DIM_CAP : raw);
      s1_in.pos = wipe_direction_ff ? req_payload.y_pos : req_payload.x_pos;
      s1_in.stg = wipe_stage_ff;
      s1_in.pix.blue  = req_payload.blue_in;
      s1_in.pix.green = req_payload.green_in;
      s1_in.pix.red   = req_payload.red_in;
      s1_in.pix.alpha = req_payload.alpha_in;
   end

   // Ramp start a = D*(stage mod 16)/32, half extent b = D/2
   always_comb begin
      logic [16:0] prod;
      prod = 17'(s1_ff.dim) * 17'(s1_ff.stg[3:0]);
      s2_in.ofs    = prod[16:5];
      s2_in.half   = s1_ff.dim[12:1];
      s2_in.pos    = s1_ff.pos;
      s2_in.regime = s1_ff.stg[5:4];
      s2_in.beyond = 13'(s1_ff.pos) >= s1_ff.dim;
      s2_in.pix    = s1_ff.pix;
   end

   // Decide the region and the distance into the ramp
   always_comb begin
      logic [12:0] pos_w;
      logic [12:0] ofs_w;
      logic [12:0] end_w;
      pos_w = 13'(s2_ff.pos);
      ofs_w = 13'(s2_ff.ofs);
      end_w = ofs_w + 13'(s2_ff.half);
      s3_in.kind  = KIND_ZERO;
      s3_in.delta = 12'd0;
      s3_in.half  = s2_ff.half;
      s3_in.pix   = s2_ff.pix;
      if (!s2_ff.beyond) begin
         case (s2_ff.regime)
            2'd0: begin
               if (pos_w < ofs_w) begin
                  s3_in.kind  = KIND_UP;
                  s3_in.delta = 12'(ofs_w - pos_w);
               end
            end
            2'd1: begin
               if (pos_w < ofs_w) begin
                  s3_in.kind = KIND_FULL;
               end else if (pos_w < end_w) begin
                  s3_in.kind  = KIND_DOWN;
                  s3_in.delta = 12'(pos_w - ofs_w);
               end
            end
            default: begin
               if (pos_w < end_w) begin
                  s3_in.kind = KIND_FULL;
               end else begin
                  s3_in.kind  = KIND_DOWN;
                  s3_in.delta = 12'(pos_w - end_w);
               end
            end
         endcase
      end
   end

   // Dividend 255*delta; it stays below 256*half, so the quotient fits eight bits
   always_comb begin
      dv_in.rem  = (20'(s3_ff.delta) << 8) - 20'(s3_ff.delta);
      dv_in.half = s3_ff.half;
      dv_in.quo  = 8'd0;
      dv_in.kind = s3_ff.kind;
      dv_in.pix  = s3_ff.pix;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
      if (en[1]) begin
         s2_ff <= s2_in;
      end
      if (en[2]) begin
         s3_ff <= s3_in;
      end
      if (en[StDv0]) begin
         dv_ff[0] <= dv_in;
      end
      // Two quotient bits per stage, most significant first
      for (int k = 1; k <= DvStgs; k++) begin
         if (en[StDv0 + k]) begin
            dv_ff[k] <= div_step(div_step(dv_ff[k-1], 3'(9 - 2 * k)), 3'(8 - 2 * k));
         end
      end
   end

   // Merge wipe alpha, multiply colours
   always_comb begin
      logic [7:0] wipe_t;
      logic [7:0] alpha;
      case (dv_ff[DvStgs].kind)
         KIND_ZERO: wipe_t = 8'd0;
         KIND_FULL: wipe_t = ALPHA_FULL;
         KIND_UP:   wipe_t = dv_ff[DvStgs].quo;
         KIND_DOWN: wipe_t = ALPHA_FULL - dv_ff[DvStgs].quo;
         default:   wipe_t = 8'd0;
      endcase
      alpha        = dv_ff[DvStgs].pix.alpha | wipe_t;
      mp_in.alpha  = alpha;
      mp_in.prod_b = 16'(dv_ff[DvStgs].pix.blue) * 16'(alpha);
      mp_in.prod_g = 16'(dv_ff[DvStgs].pix.green) * 16'(alpha);
      mp_in.prod_r = 16'(dv_ff[DvStgs].pix.red) * 16'(alpha);
   end

   always_comb begin
      out_in.blue_out  = div255(mp_ff.prod_b);
      out_in.green_out = div255(mp_ff.prod_g);
      out_in.red_out   = div255(mp_ff.prod_r);
      out_in.alpha_out = mp_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (en[StMp]) begin
         mp_ff <= mp_in;
      end
      if (en[StOut]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = vld_ff[StOut];
   assign rsp_payload = out_ff;

   assign div_rem_ok = dv_ff[DvStgs].rem < 20'(dv_ff[DvStgs].half);
   assign colour_ok  = (out_ff.blue_out <= out_ff.alpha_out) &&
                       (out_ff.green_out <= out_ff.alpha_out) &&
                       (out_ff.red_out <= out_ff.alpha_out);

   `WAP_ASSERT_NOW(a_empty_out_accepts, !vld_ff[StOut], req_ready, "request refused, output empty")
   `WAP_ASSERT_NOW(a_div_remainder, vld_ff[StMp - 1], div_rem_ok, "remainder not below divisor")
   `WAP_ASSERT_NOW(a_colour_bound, rsp_valid, colour_ok, "premultiplied colour exceeds alpha")
   `WAP_ASSERT_NEXT(a_mp_reaches_out, vld_ff[StMp] && en[StOut], rsp_valid, "request lost at output")

endmodule

### sim/testbench.sv
// Self-checking testbench for the wipe alpha premultiply block.
module testbench;
   import wap_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [12:0] width;
      logic [12:0] height;
      logic        vertical;
      logic [5:0]  stage;
      wap_req_type pixel;
      logic        fixed;
      wap_rsp_type result;
   } probe_row_type;

   typedef struct packed {
      logic        fixed;
      wap_rsp_type value;
   } pinned_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   wap_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   wap_rsp_type rsp_payload;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = CSR_FRAME_WIDTH;
   logic [12:0] csr_wdata   = '0;

   // Shadow copy of the configuration registers
   logic [12:0] cfg_width    = FRAME_WIDTH_RST;
   logic [12:0] cfg_height   = FRAME_HEIGHT_RST;
   logic        cfg_vertical = 1'b0;
   logic [5:0]  cfg_stage    = '0;

   probe_row_type     probe_rows[$];
   pinned_result_type offered_rows[$];
   wap_rsp_type       awaited_pixels[$];
   string             lane[4] = '{"alpha_out", "red_out", "green_out", "blue_out"};
   int                failures    = 0;
   int unsigned       cycle_count = 0;
   bit                steady      = 1'b0;
   bit                squeeze     = 1'b0;

   wipe_alpha_premultiply u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned axis_extent(input logic [12:0] extent);
      int unsigned d;
      d = extent;
      if (d < 2) d = 2;
      if (d > MAX_DIM) d = MAX_DIM;
      return d;
   endfunction

   function automatic logic [7:0] wipe_ramp(input logic [12:0] extent, input logic [11:0] coord,
                                            input logic [5:0] step);
      int unsigned d, p, a, b, t;
      d = axis_extent(extent);
      p = coord;
      a = d * step[3:0] / 32;
      b = d / 2;
      if (p >= d) t = 0;
      else if (step[5:4] == 2'd0) t = (p < a) ? 255 * (a - p) / b : 0;
      else if (step[5:4] == 2'd1) begin
         if (p < a) t = 255;
         else if (p < a + b) t = 255 - 255 * (p - a) / b;
         else t = 0;
      end else t = (p < a + b) ? 255 : 255 - 255 * (p - a - b) / b;
      return t[7:0];
   endfunction

   function automatic logic [7:0] scale(input logic [7:0] chan, input logic [7:0] alpha);
      int unsigned prod;
      prod = chan * alpha;
      prod = prod / 255;
      return prod[7:0];
   endfunction

   function automatic wap_rsp_type premultiply_pixel(input wap_req_type px);
      wap_rsp_type res;
      logic [7:0]  t;
      t = cfg_vertical ? wipe_ramp(cfg_height, px.y_pos, cfg_stage)
                       : wipe_ramp(cfg_width, px.x_pos, cfg_stage);
      res.alpha_out = px.alpha_in | t;
      res.blue_out  = scale(px.blue_in, res.alpha_out);
      res.green_out = scale(px.green_in, res.alpha_out);
      res.red_out   = scale(px.red_in, res.alpha_out);
      return res;
   endfunction

   function automatic void add_probe(input logic [12:0] w, input logic [12:0] h, input logic v,
                                     input logic [5:0] s, input logic [11:0] x,
                                     input logic [11:0] y, input logic [31:0] bgra,
                                     input logic fixed, input logic [31:0] result);
      probe_row_type row;
      row.width  = w;
      row.height = h;
      row.vertical = v;
      row.stage  = s;
      row.pixel  = {x, y, bgra};
      row.fixed  = fixed;
      row.result = result;
      probe_rows.push_back(row);
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 17) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [12:0] pick_extent();
      case ($urandom_range(0, 9))
         0: return 13'($urandom_range(0, 1));
         1: return 13'd2;
         2, 3, 4: return 13'($urandom_range(2, 40));
         5, 6: return 13'($urandom_range(41, 4096));
         7: return 13'd4096;
         8: return 13'($urandom_range(4097, 8190));
         default: return 13'd8191;
      endcase
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic wap_req_type make_pixel();
      wap_req_type px;
      int unsigned span, p;
      span = axis_extent(cfg_vertical ? cfg_height : cfg_width);
      case ($urandom_range(0, 9))
         0: p = $urandom_range(0, 4095);
         1: p = (span > 4095) ? 4095 : span;
         2: p = span - 1;
         default: p = $urandom_range(0, span - 1);
      endcase
      px.x_pos    = 12'($urandom_range(0, 4095));
      px.y_pos    = 12'($urandom_range(0, 4095));
      if (cfg_vertical) px.y_pos = p[11:0];
      else px.x_pos = p[11:0];
      px.blue_in  = pick_level();
      px.green_in = pick_level();
      px.red_in   = pick_level();
      px.alpha_in = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      return px;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width    = value;
         CSR_FRAME_HEIGHT:   cfg_height   = value;
         CSR_WIPE_DIRECTION: cfg_vertical = value[0];
         CSR_WIPE_STAGE:     cfg_stage    = value[5:0];
         default: ;
      endcase
   endtask

   // Hold valid until the request is taken
   task automatic send_pixel(input wap_req_type px, input logic fixed, input wap_rsp_type value);
      int gap;
      gap = pick_gap();
      offered_rows.push_back(pinned_result_type'({fixed, value}));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (offered_rows.size() != 0 || awaited_pixels.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : watch
      pinned_result_type slot;
      wap_rsp_type       want;
      if (!reset && req_valid && req_ready) begin
         slot = offered_rows.pop_front();
         awaited_pixels.push_back(slot.fixed ? slot.value : premultiply_pixel(req_payload));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_pixels.size() == 0) begin
            $display("%0t: response with nothing awaited: %h", $time, rsp_payload);
            failures++;
         end else begin
            want = awaited_pixels.pop_front();
            for (int k = 0; k < 4; k++) begin
               if (want[8*k +: 8] !== rsp_payload[8*k +: 8]) begin
                  $display("%0t: %s expected %0d got %0d", $time, lane[k],
                           want[8*k +: 8], rsp_payload[8*k +: 8]);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wipe_alpha_premultiply: mismatch");
         $finish;
      end
   end

   // Response side: random back-pressure, plus one long hold when asked
   initial begin : sink
      int run, hold;
      while (reset) @(posedge clock);
      forever begin
         run = $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (squeeze) begin
            hold = 150;
            squeeze = 1'b0;
         end else if ($urandom_range(0, 9) == 0) hold = $urandom_range(10, 40);
         else if ($urandom_range(0, 2) == 0) hold = 0;
         else hold = $urandom_range(1, 3);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      probe_row_type row;
      int            count;
      // Reset values, then each ramp regime at its edges, the far axis, clamped extents
      add_probe(640, 480, 0, 0, 0, 0, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(640, 480, 0, 0, 4095, 4095, 32'hFFFFFFFF, 1, 32'hFFFFFFFF);
      add_probe(640, 480, 0, 15, 0, 0, 32'h80402000, 0, '0);
      add_probe(640, 480, 0, 15, 299, 0, 32'hFFFFFF00, 0, '0);
      add_probe(640, 480, 0, 15, 300, 0, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(640, 480, 0, 16, 0, 0, 32'h12345600, 1, 32'h123456FF);
      add_probe(640, 480, 0, 16, 319, 0, 32'hFF80010F, 0, '0);
      add_probe(640, 480, 0, 16, 320, 0, 32'hFFFFFFAA, 0, '0);
      add_probe(640, 480, 0, 31, 299, 0, 32'h01020300, 1, 32'h010203FF);
      add_probe(640, 480, 0, 31, 620, 0, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(640, 480, 0, 32, 319, 0, 32'hA55AFF00, 1, 32'hA55AFFFF);
      add_probe(640, 480, 0, 32, 639, 0, 32'hFFFFFF00, 0, '0);
      add_probe(640, 480, 0, 32, 640, 0, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(640, 480, 0, 47, 639, 0, 32'hC8643200, 0, '0);
      add_probe(640, 480, 0, 48, 320, 0, 32'hFFFFFF00, 0, '0);
      add_probe(640, 480, 0, 63, 100, 0, 32'h11223300, 1, 32'h112233FF);
      add_probe(640, 480, 1, 32, 4095, 0, 32'h7F7F7F00, 1, 32'h7F7F7FFF);
      add_probe(640, 480, 1, 32, 0, 479, 32'hFFFFFF00, 0, '0);
      add_probe(640, 480, 1, 32, 0, 480, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(0, 480, 0, 40, 0, 0, 32'hFFFFFF00, 1, 32'hFFFFFFFF);
      add_probe(1, 480, 0, 40, 2, 0, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(8191, 480, 0, 47, 4095, 0, 32'hFFFFFF00, 0, '0);
      add_probe(8191, 8191, 1, 0, 0, 4095, 32'hFFFFFF00, 1, 32'h00000000);
      add_probe(640, 0, 1, 47, 0, 1, 32'hFFFFFF00, 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         if (row.width != cfg_width || row.height != cfg_height ||
             row.vertical != cfg_vertical || row.stage != cfg_stage) begin
            drain();
            write_reg(CSR_FRAME_WIDTH, row.width);
            write_reg(CSR_FRAME_HEIGHT, row.height);
            write_reg(CSR_WIPE_DIRECTION, 13'(row.vertical));
            write_reg(CSR_WIPE_STAGE, 13'(row.stage));
         end
         send_pixel(row.pixel, row.fixed, row.result);
      end

      for (int phase = 0; phase < 15; phase++) begin
         drain();
         write_reg(CSR_FRAME_WIDTH, pick_extent());
         write_reg(CSR_FRAME_HEIGHT, pick_extent());
         write_reg(CSR_WIPE_DIRECTION, 13'($urandom_range(0, 1)));
         write_reg(CSR_WIPE_STAGE, ($urandom_range(0, 7) == 0) ? 13'($urandom_range(48, 63))
                                                               : 13'($urandom_range(0, 47)));
         // Gapless bursts in every fourth phase; one long burst against a stalled receiver to fill the pipeline
         steady = (phase % 4 == 3) || (phase == 7);
         if (phase == 7) squeeze = 1'b1;
         count = (phase == 7) ? 80 : 24;
         repeat (count) send_pixel(make_pixel(), 1'b0, '0);
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0) $display("wipe_alpha_premultiply: match");
      else $display("wipe_alpha_premultiply: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/wap_pkg.sv
rtl/wipe_alpha_premultiply.sv
sim/testbench.sv
